// File: hw/rtl/stable_priority_queue_with_remove_macros.svh
// assertion macros for the stable priority queue
`ifndef STABLE_PRIORITY_QUEUE_WITH_REMOVE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_WITH_REMOVE_MACROS_SVH
`ifndef ASSERT_OFF
`define SPQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spqr same-cycle check failed");
`define SPQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spqr next-cycle check failed");
`else
`define SPQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/spqr_pkg.sv
// shared types, codes and constants for the stable priority queue
package spqr_pkg;

  localparam int SPQR_DEPTH = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] item_id;
    logic [2:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        head_valid;
    logic [15:0] head_id;
    logic [2:0]  head_priority;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RESOLVE,
    S_PURGE,
    S_DONE
  } fsm_state_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_INSERT,
    DP_POP,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_DROP_TAIL,
    DP_PURGE_INIT,
    DP_PURGE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_cmd;
    logic       empty;
    logic       full;
    logic       head_match;
    logic       scan_last;
    logic       tail_hit;
    logic       found;
  } dp_stat_t;

endpackage

// File: hw/rtl/spqr_dp.sv
// datapath: sorted slot array, entry count, scan counters and result register
`include "stable_priority_queue_with_remove_macros.svh"
module spqr_dp #(
  parameter int DEPTH = spqr_pkg::SPQR_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spqr_pkg::in_item_t   in_item,
  input  spqr_pkg::dp_cmd_t    cmd,
  output spqr_pkg::dp_stat_t   stat,
  output spqr_pkg::out_item_t  out_item
);
  import spqr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0]   slot_id_r  [DEPTH];
  logic [15:0]   slot_id_nxt[DEPTH];
  logic [2:0]    slot_pri_r  [DEPTH];
  logic [2:0]    slot_pri_nxt[DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic          found_r, found_nxt;
  logic          tail_r, tail_nxt;
  in_item_t      req_r, req_nxt;
  out_item_t     out_r, out_nxt;

  logic [DEPTH-1:0] live;
  logic [DEPTH-1:0] ge;
  logic             shift_en;
  logic             wrap_en;
  logic             ins_en;
  logic             head_hit;
  logic             scan_last;

  assign head_hit  = (slot_id_r[0] == req_r.item_id);
  assign scan_last = (step_r == n_r - CW'(1));

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      live[k] = (CW'(k) < count_r);
      ge[k]   = live[k] && (slot_pri_r[k] >= req_r.priority_req);
    end
  end

  always_comb begin
    count_nxt = count_r;
    step_nxt  = step_r;
    n_nxt     = n_r;
    first_nxt = first_r;
    found_nxt = found_r;
    tail_nxt  = tail_r;
    req_nxt   = req_r;
    out_nxt   = out_r;
    shift_en  = 1'b0;
    wrap_en   = 1'b0;
    ins_en    = 1'b0;
    case (cmd.op)
      DP_LOAD: begin
        req_nxt = in_item;
      end
      DP_INSERT: begin
        ins_en    = 1'b1;
        count_nxt = count_r + CW'(1);
      end
      DP_POP: begin
        shift_en  = 1'b1;
        count_nxt = count_r - CW'(1);
      end
      DP_SCAN_INIT: begin
        step_nxt  = '0;
        n_nxt     = count_r;
        found_nxt = 1'b0;
        tail_nxt  = 1'b0;
      end
      DP_SCAN: begin
        shift_en = 1'b1;
        wrap_en  = 1'b1;
        step_nxt = step_r + CW'(1);
        if (head_hit && !found_r) begin
          found_nxt = 1'b1;
          first_nxt = step_r;
        end
        if (head_hit && scan_last) begin
          tail_nxt = 1'b1;
        end
      end
      DP_DROP_TAIL: begin
        count_nxt = count_r - CW'(1);
      end
      DP_PURGE_INIT: begin
        step_nxt = '0;
      end
      DP_PURGE: begin
        shift_en = 1'b1;
        step_nxt = step_r + CW'(1);
        if (step_r == first_r) begin
          count_nxt = count_r - CW'(1);
        end else begin
          wrap_en = 1'b1;
        end
      end
      DP_EMIT: begin
        out_nxt.status        = cmd.status;
        out_nxt.entry_count   = 5'(count_r);
        out_nxt.head_valid    = (count_r != '0);
        out_nxt.head_id       = (count_r != '0) ? slot_id_r[0] : '0;
        out_nxt.head_priority = (count_r != '0) ? slot_pri_r[0] : '0;
      end
      default: begin
      end
    endcase
  end

  // slot moves: insert opens a gap, shift closes toward the head, wrap refills the tail
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      slot_id_nxt[k]  = slot_id_r[k];
      slot_pri_nxt[k] = slot_pri_r[k];
    end
    if (ins_en) begin
      if (!ge[0]) begin
        slot_id_nxt[0]  = req_r.item_id;
        slot_pri_nxt[0] = req_r.priority_req;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (!ge[k]) begin
          if (ge[k-1]) begin
            slot_id_nxt[k]  = req_r.item_id;
            slot_pri_nxt[k] = req_r.priority_req;
          end else begin
            slot_id_nxt[k]  = slot_id_r[k-1];
            slot_pri_nxt[k] = slot_pri_r[k-1];
          end
        end
      end
    end
    if (shift_en) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        slot_id_nxt[k]  = slot_id_r[k+1];
        slot_pri_nxt[k] = slot_pri_r[k+1];
      end
    end
    if (wrap_en) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (CW'(k) == count_r - CW'(1)) begin
          slot_id_nxt[k]  = slot_id_r[0];
          slot_pri_nxt[k] = slot_pri_r[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      found_r <= 1'b0;
      tail_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      found_r <= found_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      slot_id_r[k]  <= slot_id_nxt[k];
      slot_pri_r[k] <= slot_pri_nxt[k];
    end
    step_r  <= step_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    req_r   <= req_nxt;
    out_r   <= out_nxt;
  end

  assign stat.req_cmd    = req_r.cmd;
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.head_match = (count_r != '0) && head_hit;
  assign stat.scan_last  = scan_last;
  assign stat.tail_hit   = tail_r;
  assign stat.found      = found_r;
  assign out_item        = out_r;

  `SPQR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `SPQR_ASSERT_NXT(a_insert_grows, clk, rst_n, cmd.op == DP_INSERT,
                   count_r == $past(count_r) + CW'(1))
  `SPQR_ASSERT_NXT(a_drop_shrinks, clk, rst_n, cmd.op == DP_POP || cmd.op == DP_DROP_TAIL,
                   count_r == $past(count_r) - CW'(1))

endmodule

// File: hw/rtl/spqr_ctrl.sv
// controller: command decode and sequencing of the remove scan
`include "stable_priority_queue_with_remove_macros.svh"
module spqr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  spqr_pkg::dp_stat_t stat,
  output spqr_pkg::dp_cmd_t  cmd
);
  import spqr_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd.op     = DP_IDLE;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (stat.req_cmd)
          CMD_INSERT: begin
            if (stat.full) begin
              status_nxt = STAT_FULL;
            end else begin
              cmd.op     = DP_INSERT;
              status_nxt = STAT_OK;
            end
          end
          CMD_POP: begin
            if (stat.empty) begin
              status_nxt = STAT_EMPTY;
            end else begin
              cmd.op     = DP_POP;
              status_nxt = STAT_OK;
            end
          end
          CMD_REMOVE: begin
            if (stat.empty) begin
              status_nxt = STAT_EMPTY;
            end else if (stat.head_match) begin
              cmd.op     = DP_POP;
              status_nxt = STAT_OK;
            end else begin
              cmd.op    = DP_SCAN_INIT;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            status_nxt = STAT_OK;
          end
        endcase
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (stat.scan_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (stat.tail_hit) begin
          cmd.op     = DP_DROP_TAIL;
          status_nxt = STAT_OK;
          state_nxt  = S_DONE;
        end else if (stat.found) begin
          cmd.op    = DP_PURGE_INIT;
          state_nxt = S_PURGE;
        end else begin
          status_nxt = STAT_NOTFOUND;
          state_nxt  = S_DONE;
        end
      end
      S_PURGE: begin
        cmd.op = DP_PURGE;
        if (stat.scan_last) begin
          status_nxt = STAT_OK;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        cmd.op    = DP_EMIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `SPQR_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  `SPQR_ASSERT_NXT(a_accept_decode, clk, rst_n, start && !busy, state_r == S_DECODE)
  `SPQR_ASSERT_NXT(a_done_strobe, clk, rst_n, state_r == S_DONE, out_valid_r)
  `SPQR_ASSERT_IMP(a_purge_found, clk, rst_n, state_r == S_PURGE, stat.found)

endmodule

// File: hw/rtl/stable_priority_queue_with_remove.sv
// Stable priority queue with remove-by-id, top level.
// Input channel: an item (cmd, item_id, priority_req) is taken on a rising edge
// with start high and busy low. Commands: insert, pop the head, remove by id.
// Result channel: out_valid is high for exactly one cycle with out_item holding
// status, entry count after the command, and the head entry (zero when empty).
// There is no backpressure; every result must be taken when shown.
// Insert, pop, unused codes, empty removes and removes that hit the head go
// straight from decode to the result. A remove that misses the head walks the
// queue by rotating the slot array, one slot per cycle: one pass when the
// tail matches or nothing matches, and a second purge pass for a match in the
// middle. The next item may be accepted in the cycle the result is shown;
// busy stays high until then, so items are taken one at a time, and remove
// throughput is set by the rotation passes over the slot array.
// Reset empties the queue; slot contents are left as they are.
module stable_priority_queue_with_remove #(
  parameter int DEPTH = spqr_pkg::SPQR_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spqr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output spqr_pkg::out_item_t out_item
);
  import spqr_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  spqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  spqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_item (out_item)
  );

endmodule
